// File: rtl/rpn_calc_pkg.sv
// shared types, widths, operation codes and helpers for the rpn stack calculator
package rpn_calc_pkg;

   // field widths
   localparam int VALUE_W     = 48;
   localparam int MODE_W      = 3;
   localparam int DEPTH_OUT_W = 8;
   localparam int FRAC_W      = 16;
   localparam int INT_W       = VALUE_W - FRAC_W;

   // default number of stack entries
   localparam int DEFAULT_STACK_DEPTH = 128;

   // shared arithmetic unit sizing
   localparam int DIVIDEND_W = 64;
   localparam int ADD_W      = VALUE_W + 1;
   localparam int SUM_W      = ADD_W + 1;
   localparam int PROD_MAG_W = 2 * VALUE_W - FRAC_W;
   localparam int MUL_STEPS  = VALUE_W;
   localparam int DIV_STEPS  = DIVIDEND_W;
   localparam int STEP_W     = $clog2(DIV_STEPS + 1);

   // operation codes
   localparam logic [MODE_W-1:0] MODE_PUSH = 3'd0;
   localparam logic [MODE_W-1:0] MODE_ADD  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_SUB  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_MUL  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_DIV  = 3'd4;
   localparam logic [MODE_W-1:0] MODE_MOD  = 3'd5;
   localparam logic [MODE_W-1:0] MODE_POP  = 3'd6;

   typedef logic [VALUE_W-1:0] value_type;

   // saturation limits in raw q32.16 units
   localparam value_type VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam value_type VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

   // sequencer to arithmetic unit
   typedef struct packed {
      logic start;
      logic is_div;
   } alu_ctrl_type;

   // arithmetic unit to sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } alu_stat_type;

   // absolute value of a two's complement value, most negative maps to 2^47
   function automatic value_type magnitude(input value_type v);
      value_type m;
      m = v[VALUE_W-1] ? value_type'(~v + value_type'(1)) : v;
      return m;
   endfunction

endpackage

// File: rtl/rpn_calc_req_if.sv
// request channel: operation and pushed value
interface rpn_calc_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [rpn_calc_pkg::MODE_W-1:0]        mode;
   logic signed [rpn_calc_pkg::VALUE_W-1:0] operand_value;

   modport source (output valid, output mode, output operand_value, input ready);
   modport sink (input valid, input mode, input operand_value, output ready);
endinterface

// File: rtl/rpn_calc_rsp_if.sv
// response channel: shown or top value, depth and status flags
interface rpn_calc_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [rpn_calc_pkg::VALUE_W-1:0] result_value;
   logic [rpn_calc_pkg::DEPTH_OUT_W-1:0]    stack_depth;
   logic                                    shown;
   logic                                    overflow_flag;
   logic                                    underflow_flag;
   logic                                    divide_by_zero_flag;
   logic                                    saturated_flag;

   modport source (output valid, output result_value, output stack_depth, output shown,
                   output overflow_flag, output underflow_flag,
                   output divide_by_zero_flag, output saturated_flag, input ready);
   modport sink (input valid, input result_value, input stack_depth, input shown,
                 input overflow_flag, input underflow_flag,
                 input divide_by_zero_flag, input saturated_flag, output ready);
endinterface

// File: rtl/rpn_stack_calculator_core.sv
// Reverse Polish calculator on signed Q32.16 values with a STACK_DEPTH-entry stack held in a
// single-port-read memory. The core takes one operation at a time: ready is high only while it
// is idle, and every accepted beat produces exactly one response beat. Multiply is a 48-step
// shift-add and divide and modulo are a 64-step restoring divide on the shared adder of the
// arithmetic unit, which retires one multiplier or quotient bit per cycle; every stack access
// goes through the registered memory read. The response beat holds until it is taken, and the
// core is ready again in the cycle after that. Stack entries are not cleared at reset; only
// entries below the stack pointer are ever read.
module rpn_stack_calculator_core #(
   parameter int STACK_DEPTH = rpn_calc_pkg::DEFAULT_STACK_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   rpn_calc_req_if.sink      req_bus,
   rpn_calc_rsp_if.source    rsp_bus
);

   localparam int VW     = rpn_calc_pkg::VALUE_W;
   localparam int FW     = rpn_calc_pkg::FRAC_W;
   localparam int IW     = rpn_calc_pkg::INT_W;
   localparam int DW     = rpn_calc_pkg::DIVIDEND_W;
   localparam int PW     = rpn_calc_pkg::PROD_MAG_W;
   localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int PTR_W  = $clog2(STACK_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_FULL = PTR_W'(STACK_DEPTH);

   typedef enum logic [3:0] {
      S_IDLE, S_POP_Y, S_GET_Y, S_AFTER_Y, S_POP_X, S_GET_X, S_EXEC,
      S_ARITH, S_FIX, S_PUSH, S_TOP, S_TOP_GET, S_OUT
   } state_type;

   state_type                         state_ff;
   logic [PTR_W-1:0]                  sp_ff;
   logic [rpn_calc_pkg::MODE_W-1:0]   mode_ff;
   rpn_calc_pkg::value_type           x_ff;
   rpn_calc_pkg::value_type           y_ff;
   rpn_calc_pkg::value_type           push_val_ff;
   logic [PW-1:0]                     res_mag_ff;
   logic                              neg_ff;
   rpn_calc_pkg::value_type           result_ff;
   logic                              shown_ff;
   logic                              ovf_ff;
   logic                              unf_ff;
   logic                              dz_ff;
   logic                              sat_ff;

   logic [PTR_W-1:0]                  sp_dec;
   rpn_calc_pkg::value_type           mag_x;
   rpn_calc_pkg::value_type           mag_y;
   logic                              y_int_zero;
   logic                              mem_we;
   rpn_calc_pkg::value_type           mem_rdata;
   rpn_calc_pkg::alu_ctrl_type        alu_ctrl;
   rpn_calc_pkg::alu_stat_type        alu_stat;
   logic [DW-1:0]                     alu_a;
   rpn_calc_pkg::value_type           alu_b;
   rpn_calc_pkg::value_type           alu_hi;
   logic [DW-1:0]                     alu_lo;
   rpn_calc_pkg::value_type           res_lo;
   rpn_calc_pkg::value_type           res_neg;
   logic                              over_neg;
   logic                              over_pos;

   // operand magnitudes and the integer-part zero test for modulo
   assign sp_dec     = sp_ff - PTR_W'(1);
   assign mag_x      = rpn_calc_pkg::magnitude(x_ff);
   assign mag_y      = rpn_calc_pkg::magnitude(y_ff);
   assign y_int_zero = (mag_y[VW-1:FW] == '0);

   // stack memory: write at the pointer, read just below it
   assign mem_we = (state_ff == S_PUSH) && (sp_ff != PTR_FULL);

   rpn_calc_stack #(
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (sp_ff[ADDR_W-1:0]),
      .wr_data (push_val_ff),
      .rd_addr (sp_dec[ADDR_W-1:0]),
      .rd_data (mem_rdata)
   );

   // arithmetic unit operands, loaded when the sequencer starts it
   always_comb begin
      alu_ctrl.start  = (state_ff == S_EXEC) &&
                        ((mode_ff == rpn_calc_pkg::MODE_MUL) ||
                         (mode_ff == rpn_calc_pkg::MODE_DIV) ||
                         (mode_ff == rpn_calc_pkg::MODE_MOD));
      alu_ctrl.is_div = (mode_ff != rpn_calc_pkg::MODE_MUL);
      unique case (mode_ff)
         rpn_calc_pkg::MODE_MUL: begin
            alu_a = {{(DW-VW){1'b0}}, mag_x};
            alu_b = mag_y;
         end
         rpn_calc_pkg::MODE_DIV: begin
            alu_a = {mag_x, {FW{1'b0}}};
            alu_b = mag_y;
         end
         default: begin
            alu_a = {{(DW-IW){1'b0}}, mag_x[VW-1:FW]};
            alu_b = {{FW{1'b0}}, mag_y[VW-1:FW]};
         end
      endcase
   end

   rpn_calc_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (alu_ctrl),
      .a_val  (alu_a),
      .b_val  (alu_b),
      .stat   (alu_stat),
      .hi_out (alu_hi),
      .lo_out (alu_lo)
   );

   // sign and clamp of the unsigned result magnitude
   assign res_lo   = res_mag_ff[VW-1:0];
   assign res_neg  = rpn_calc_pkg::value_type'(~res_lo + rpn_calc_pkg::value_type'(1));
   assign over_neg = (res_mag_ff > PW'(rpn_calc_pkg::VALUE_MIN));
   assign over_pos = (res_mag_ff > PW'(rpn_calc_pkg::VALUE_MAX));

   // sequencer: pops, arithmetic, push and read-back of the new top
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sp_ff    <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_bus.valid) begin
                  mode_ff     <= req_bus.mode;
                  push_val_ff <= req_bus.operand_value;
                  shown_ff    <= 1'b0;
                  ovf_ff      <= 1'b0;
                  unf_ff      <= 1'b0;
                  dz_ff       <= 1'b0;
                  sat_ff      <= 1'b0;
                  priority if (req_bus.mode == rpn_calc_pkg::MODE_PUSH) begin
                     state_ff <= S_PUSH;
                  end else if (req_bus.mode > rpn_calc_pkg::MODE_POP) begin
                     state_ff <= S_TOP;
                  end else begin
                     state_ff <= S_POP_Y;
                  end
               end
            end
            S_POP_Y: begin
               if (sp_ff != '0) begin
                  sp_ff    <= sp_dec;
                  state_ff <= S_GET_Y;
               end else begin
                  y_ff     <= '0;
                  unf_ff   <= 1'b1;
                  state_ff <= S_AFTER_Y;
               end
            end
            S_GET_Y: begin
               y_ff     <= mem_rdata;
               state_ff <= S_AFTER_Y;
            end
            S_AFTER_Y: begin
               priority if (mode_ff == rpn_calc_pkg::MODE_POP) begin
                  result_ff <= y_ff;
                  shown_ff  <= 1'b1;
                  state_ff  <= S_OUT;
               end else if ((mode_ff == rpn_calc_pkg::MODE_DIV) && (y_ff == '0)) begin
                  dz_ff    <= 1'b1;
                  state_ff <= S_TOP;
               end else if ((mode_ff == rpn_calc_pkg::MODE_MOD) && y_int_zero) begin
                  dz_ff    <= 1'b1;
                  state_ff <= S_TOP;
               end else begin
                  state_ff <= S_POP_X;
               end
            end
            S_POP_X: begin
               if (sp_ff != '0) begin
                  sp_ff    <= sp_dec;
                  state_ff <= S_GET_X;
               end else begin
                  x_ff     <= '0;
                  unf_ff   <= 1'b1;
                  state_ff <= S_EXEC;
               end
            end
            S_GET_X: begin
               x_ff     <= mem_rdata;
               state_ff <= S_EXEC;
            end
            S_EXEC: begin
               neg_ff <= (mode_ff == rpn_calc_pkg::MODE_MOD) ? x_ff[VW-1]
                                                             : (x_ff[VW-1] ^ y_ff[VW-1]);
               unique case (mode_ff)
                  rpn_calc_pkg::MODE_ADD: begin
                     push_val_ff <= x_ff + y_ff;
                     state_ff    <= S_PUSH;
                  end
                  rpn_calc_pkg::MODE_SUB: begin
                     push_val_ff <= x_ff - y_ff;
                     state_ff    <= S_PUSH;
                  end
                  default: begin
                     state_ff <= S_ARITH;
                  end
               endcase
            end
            S_ARITH: begin
               if (alu_stat.done) begin
                  unique case (mode_ff)
                     rpn_calc_pkg::MODE_MUL: res_mag_ff <= {alu_hi, alu_lo[VW-1:FW]};
                     rpn_calc_pkg::MODE_DIV: res_mag_ff <= {{(PW-DW){1'b0}}, alu_lo};
                     default: res_mag_ff <= {{(PW-VW){1'b0}}, alu_hi[IW-1:0], {FW{1'b0}}};
                  endcase
                  state_ff <= S_FIX;
               end
            end
            S_FIX: begin
               priority if (mode_ff == rpn_calc_pkg::MODE_MOD) begin
                  push_val_ff <= neg_ff ? res_neg : res_lo;
               end else if (neg_ff) begin
                  if (over_neg) begin
                     push_val_ff <= rpn_calc_pkg::VALUE_MIN;
                     sat_ff      <= 1'b1;
                  end else begin
                     push_val_ff <= res_neg;
                  end
               end else begin
                  if (over_pos) begin
                     push_val_ff <= rpn_calc_pkg::VALUE_MAX;
                     sat_ff      <= 1'b1;
                  end else begin
                     push_val_ff <= res_lo;
                  end
               end
               state_ff <= S_PUSH;
            end
            S_PUSH: begin
               if (sp_ff != PTR_FULL) begin
                  sp_ff <= sp_ff + PTR_W'(1);
               end else begin
                  ovf_ff <= 1'b1;
               end
               state_ff <= S_TOP;
            end
            S_TOP: begin
               if (sp_ff == '0) begin
                  result_ff <= '0;
                  state_ff  <= S_OUT;
               end else begin
                  state_ff <= S_TOP_GET;
               end
            end
            S_TOP_GET: begin
               result_ff <= mem_rdata;
               state_ff  <= S_OUT;
            end
            S_OUT: begin
               if (rsp_bus.ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // channel handshakes and response beat
   assign req_bus.ready               = (state_ff == S_IDLE);
   assign rsp_bus.valid               = (state_ff == S_OUT);
   assign rsp_bus.result_value        = result_ff;
   assign rsp_bus.stack_depth         = rpn_calc_pkg::DEPTH_OUT_W'(sp_ff);
   assign rsp_bus.shown               = shown_ff;
   assign rsp_bus.overflow_flag       = ovf_ff;
   assign rsp_bus.underflow_flag      = unf_ff;
   assign rsp_bus.divide_by_zero_flag = dz_ff;
   assign rsp_bus.saturated_flag      = sat_ff;

   // the stack pointer never passes the stack size
   a_sp_range: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= PTR_FULL)
      else $error("stack pointer beyond stack size");

   // no new request is taken while a response beat is pending
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      !(req_bus.ready && rsp_bus.valid))
      else $error("request ready while response pending");

   // a shown pop carries no arithmetic or push status
   a_shown_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.shown) |->
         !(rsp_bus.overflow_flag || rsp_bus.divide_by_zero_flag || rsp_bus.saturated_flag))
      else $error("shown value with arithmetic status set");

   // the arithmetic unit is started only when free
   a_alu_free: assert property (@(posedge clock) disable iff (reset)
      alu_ctrl.start |-> !alu_stat.busy)
      else $error("arithmetic unit restarted while busy");

endmodule

// File: rtl/rpn_calc_alu.sv
// shared iterative unit: shift-add multiply and restoring divide on one adder
module rpn_calc_alu (
   input  logic                                      clock,
   input  logic                                      reset,
   input  rpn_calc_pkg::alu_ctrl_type                ctrl,
   input  logic [rpn_calc_pkg::DIVIDEND_W-1:0]       a_val,
   input  rpn_calc_pkg::value_type                   b_val,
   output rpn_calc_pkg::alu_stat_type                stat,
   output rpn_calc_pkg::value_type                   hi_out,
   output logic [rpn_calc_pkg::DIVIDEND_W-1:0]       lo_out
);

   localparam int VW = rpn_calc_pkg::VALUE_W;
   localparam int DW = rpn_calc_pkg::DIVIDEND_W;
   localparam int AW = rpn_calc_pkg::ADD_W;
   localparam int SW = rpn_calc_pkg::SUM_W;
   localparam int CW = rpn_calc_pkg::STEP_W;

   logic                     busy_ff;
   logic                     done_ff;
   logic                     div_ff;
   logic [CW-1:0]            count_ff;
   logic [AW-1:0]            hi_ff;
   logic [DW-1:0]            lo_ff;
   rpn_calc_pkg::value_type  b_ff;

   logic [AW-1:0]            add_a;
   logic [AW-1:0]            add_b;
   logic                     sub;
   logic [SW-1:0]            sum;
   logic [AW-1:0]            hi_in;
   logic [DW-1:0]            lo_in;

   // one adder step: divide shifts the partial remainder and trial-subtracts,
   // multiply adds the multiplicand when the low multiplier bit is set
   always_comb begin
      if (div_ff) begin
         add_a = {hi_ff[VW-1:0], lo_ff[DW-1]};
         add_b = {1'b0, b_ff};
         sub   = 1'b1;
      end else begin
         add_a = hi_ff;
         add_b = lo_ff[0] ? {1'b0, b_ff} : '0;
         sub   = 1'b0;
      end
      sum = {1'b0, add_a} + {1'b0, (sub ? ~add_b : add_b)} + SW'(sub);
      if (div_ff) begin
         hi_in = sum[AW] ? sum[AW-1:0] : add_a;
         lo_in = {lo_ff[DW-2:0], sum[AW]};
      end else begin
         hi_in = sum[SW-1:1];
         lo_in = {{(DW-VW){1'b0}}, sum[0], lo_ff[VW-1:1]};
      end
   end

   // step counter and operand registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (ctrl.start) begin
            busy_ff  <= 1'b1;
            div_ff   <= ctrl.is_div;
            count_ff <= ctrl.is_div ? CW'(rpn_calc_pkg::DIV_STEPS)
                                    : CW'(rpn_calc_pkg::MUL_STEPS);
            hi_ff    <= '0;
            lo_ff    <= a_val;
            b_ff     <= b_val;
         end else if (busy_ff) begin
            hi_ff    <= hi_in;
            lo_ff    <= lo_in;
            count_ff <= count_ff - CW'(1);
            if (count_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign hi_out    = hi_ff[VW-1:0];
   assign lo_out    = lo_ff;

   // done is a single-cycle pulse
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("alu done held for more than one cycle");

   // a running operation always has steps left
   a_count_live: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !ctrl.start) |-> (count_ff != '0))
      else $error("alu busy with zero step count");

endmodule

// File: rtl/rpn_calc_stack.sv
// stack storage: one write port, one registered read port
module rpn_calc_stack #(
   parameter int DEPTH = rpn_calc_pkg::DEFAULT_STACK_DEPTH
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  rpn_calc_pkg::value_type                      wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output rpn_calc_pkg::value_type                      rd_data
);

   rpn_calc_pkg::value_type mem [DEPTH];
   rpn_calc_pkg::value_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sim/rpn_stack_calculator_checker.sv
// checker for the rpn stack calculator: predicts each response beat and compares it
`timescale 1ns / 1ps

module rpn_stack_calculator_checker
   import rpn_calc_pkg::*;
#(
   parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   rpn_calc_req_if req_bus,
   rpn_calc_rsp_if rsp_bus,
   output int      mismatch_count,
   output int      pending_count,
   output int      compared_count
);

   // one predicted response beat
   typedef struct packed {
      value_type                result_value;
      logic [DEPTH_OUT_W-1:0]   stack_depth;
      logic                     shown;
      logic                     overflow_flag;
      logic                     underflow_flag;
      logic                     divide_by_zero_flag;
      logic                     saturated_flag;
   } calc_result_type;

   // shadow of the calculator stack
   value_type       stack_mem [STACK_DEPTH];
   int              stack_count;
   calc_result_type expected_results [$];

   // absolute value as an unsigned 48-bit number
   function automatic value_type abs_of(input value_type v);
      return v[VALUE_W-1] ? -v : v;
   endfunction

   // clamp a signed magnitude to the q32.16 range
   function automatic value_type clamp_signed(input logic neg, input logic [79:0] mag,
                                              inout logic sat);
      if (neg) begin
         if (mag > 80'(VALUE_MIN)) begin
            sat = 1'b1;
            return VALUE_MIN;
         end
         return value_type'(-mag);
      end
      if (mag > 80'(VALUE_MAX)) begin
         sat = 1'b1;
         return VALUE_MAX;
      end
      return value_type'(mag);
   endfunction

   function automatic logic push_entry(input value_type v);
      if (stack_count < STACK_DEPTH) begin
         stack_mem[stack_count] = v;
         stack_count++;
         return 1'b0;
      end
      return 1'b1;
   endfunction

   // an empty stack gives zero and raises underflow
   function automatic value_type pop_entry(inout logic uf);
      if (stack_count > 0) begin
         stack_count--;
         return stack_mem[stack_count];
      end
      uf = 1'b1;
      return '0;
   endfunction

   // truncated q32.16 product
   function automatic value_type fx_product(input value_type a, input value_type b,
                                            inout logic sat);
      logic [95:0] prod;
      prod = {48'd0, abs_of(a)} * {48'd0, abs_of(b)};
      return clamp_signed(a[VALUE_W-1] ^ b[VALUE_W-1], prod[95:FRAC_W], sat);
   endfunction

   // truncated q32.16 quotient, divisor known nonzero
   function automatic value_type fx_quotient(input value_type a, input value_type b,
                                             inout logic sat);
      logic [63:0] num;
      logic [63:0] quo;
      num = {16'd0, abs_of(a)} << FRAC_W;
      quo = num / {16'd0, abs_of(b)};
      return clamp_signed(a[VALUE_W-1] ^ b[VALUE_W-1], {16'd0, quo}, sat);
   endfunction

   // next-state and response for one accepted operation
   function automatic calc_result_type evaluate_op(input logic [MODE_W-1:0] op,
                                                  input value_type operand);
      calc_result_type  r;
      value_type        lhs;
      value_type        rhs;
      value_type        rem;
      logic [INT_W-1:0] lhs_int;
      logic [INT_W-1:0] rhs_int;
      logic             ovf;
      logic             uf;
      logic             dz;
      logic             sat;
      logic             show_top;
      r = '0;
      ovf = 1'b0;
      uf = 1'b0;
      dz = 1'b0;
      sat = 1'b0;
      show_top = 1'b1;
      case (op)
         MODE_PUSH: begin
            ovf = push_entry(operand);
         end
         MODE_ADD: begin
            rhs = pop_entry(uf);
            lhs = pop_entry(uf);
            ovf = push_entry(lhs + rhs);
         end
         MODE_SUB: begin
            rhs = pop_entry(uf);
            lhs = pop_entry(uf);
            ovf = push_entry(lhs - rhs);
         end
         MODE_MUL: begin
            rhs = pop_entry(uf);
            lhs = pop_entry(uf);
            ovf = push_entry(fx_product(lhs, rhs, sat));
         end
         MODE_DIV: begin
            rhs = pop_entry(uf);
            // zero divisor leaves the dividend in place
            if (rhs == '0) begin
               dz = 1'b1;
            end else begin
               lhs = pop_entry(uf);
               ovf = push_entry(fx_quotient(lhs, rhs, sat));
            end
         end
         MODE_MOD: begin
            rhs = pop_entry(uf);
            rem = abs_of(rhs);
            rhs_int = rem[VALUE_W-1:FRAC_W];
            // divisor counts as zero when its integer part is zero
            if (rhs_int == '0) begin
               dz = 1'b1;
            end else begin
               lhs = pop_entry(uf);
               rem = abs_of(lhs);
               lhs_int = rem[VALUE_W-1:FRAC_W];
               rem = {lhs_int % rhs_int, {FRAC_W{1'b0}}};
               ovf = push_entry(lhs[VALUE_W-1] ? -rem : rem);
            end
         end
         MODE_POP: begin
            r.result_value = pop_entry(uf);
            r.shown = 1'b1;
            show_top = 1'b0;
         end
         default: begin
         end
      endcase
      if (show_top)
         r.result_value = (stack_count > 0) ? stack_mem[stack_count-1] : '0;
      r.stack_depth = stack_count[DEPTH_OUT_W-1:0];
      r.overflow_flag = ovf;
      r.underflow_flag = uf;
      r.divide_by_zero_flag = dz;
      r.saturated_flag = sat;
      return r;
   endfunction

   task automatic check_field(input string field, input logic [VALUE_W-1:0] want,
                              input logic [VALUE_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", field, want, got);
         mismatch_count++;
      end
   endtask

   // watch both channels, predict on request beats, compare on response beats
   always @(posedge clock) begin : watch_channels
      calc_result_type due;
      if (reset) begin
         stack_count = 0;
         expected_results.delete();
      end else begin
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1)
            expected_results.push_back(evaluate_op(req_bus.mode, req_bus.operand_value));
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (expected_results.size() == 0) begin
               $error("response beat with no operation outstanding");
               mismatch_count++;
            end else begin
               due = expected_results.pop_front();
               check_field("result_value", due.result_value, rsp_bus.result_value);
               check_field("stack_depth", 48'(due.stack_depth), 48'(rsp_bus.stack_depth));
               check_field("shown", 48'(due.shown), 48'(rsp_bus.shown));
               check_field("overflow_flag", 48'(due.overflow_flag),
                           48'(rsp_bus.overflow_flag));
               check_field("underflow_flag", 48'(due.underflow_flag),
                           48'(rsp_bus.underflow_flag));
               check_field("divide_by_zero_flag", 48'(due.divide_by_zero_flag),
                           48'(rsp_bus.divide_by_zero_flag));
               check_field("saturated_flag", 48'(due.saturated_flag),
                           48'(rsp_bus.saturated_flag));
               compared_count++;
            end
         end
      end
      pending_count = expected_results.size();
   end

endmodule

// File: sim/rpn_stack_calculator_core_tb.sv
// testbench top for the rpn stack calculator core: stimulus, handshake idling and verdict
`timescale 1ns / 1ps

module rpn_stack_calculator_core_tb;
   import rpn_calc_pkg::*;

   localparam int                CALC_DEPTH   = DEFAULT_STACK_DEPTH;
   localparam logic [MODE_W-1:0] MODE_IGNORED = 3'd7;
   localparam int                RANDOM_OPS   = 950;
   localparam int                QUIET_TAIL   = 200;
   localparam int                DRAIN_LIMIT  = 2000;
   localparam int                SETTLE_CYCLES = 100;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic rsp_ready_q = 1'b0;

   bit   req_gaps_on = 1'b0;
   bit   rsp_stalls_on = 1'b0;
   int   stall_left = 0;
   int   shadow_depth = 0;
   int   ops_by_mode [8];
   int   fill_count = 0;
   int   drain_count = 0;

   int   mismatch_count;
   int   pending_count;
   int   compared_count;

   rpn_calc_req_if req_bus ();
   rpn_calc_rsp_if rsp_bus ();

   assign rsp_bus.ready = rsp_ready_q;

   always #1 clock = ~clock;

   rpn_stack_calculator_core #(
      .STACK_DEPTH(CALC_DEPTH)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   rpn_stack_calculator_checker #(
      .STACK_DEPTH(CALC_DEPTH)
   ) i_result_checker (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .compared_count (compared_count)
   );

   // response side back-pressure in random bursts
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready_q <= 1'b0;
      end else if (rsp_stalls_on && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 19) - 1;
         rsp_ready_q <= 1'b0;
      end else begin
         rsp_ready_q <= 1'b1;
      end
   end

   // operand mix: raw random, extremes, pure fractions, small numbers
   function automatic value_type random_value();
      value_type v;
      case ($urandom_range(0, 9))
         0, 1: v = {16'($urandom()), $urandom()};
         2: begin
            case ($urandom_range(0, 5))
               0: v = VALUE_MAX;
               1: v = VALUE_MIN;
               2: v = '0;
               3: v = '1;
               4: v = value_type'(1);
               default: v = value_type'(1) << FRAC_W;
            endcase
         end
         3: begin
            v = value_type'($urandom_range(0, 16'hffff));
            if ($urandom_range(0, 1) == 1)
               v = -v;
         end
         default: begin
            v = value_type'($urandom_range(0, 200)) - value_type'(100);
            v = v << FRAC_W;
            if ($urandom_range(0, 1) == 1)
               v[FRAC_W-1:0] = 16'($urandom());
         end
      endcase
      return v;
   endfunction

   // mostly pushes on a shallow stack so that operations find operands
   function automatic logic [MODE_W-1:0] random_mode(input int depth);
      int pick;
      pick = $urandom_range(0, 99);
      if (depth < 2 && pick < 75)
         return MODE_PUSH;
      if (pick < 38) return MODE_PUSH;
      if (pick < 48) return MODE_ADD;
      if (pick < 56) return MODE_SUB;
      if (pick < 66) return MODE_MUL;
      if (pick < 76) return MODE_DIV;
      if (pick < 86) return MODE_MOD;
      if (pick < 98) return MODE_POP;
      return MODE_IGNORED;
   endfunction

   // drive one request beat, with an optional idle burst ahead of it
   task automatic send_op(input logic [MODE_W-1:0] op, input value_type operand);
      if (req_gaps_on && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.mode <= op;
      req_bus.operand_value <= operand;
      @(posedge clock);
      while (req_bus.ready !== 1'b1)
         @(posedge clock);
      ops_by_mode[op]++;
      // rough depth estimate, only used to steer the stimulus
      case (op)
         MODE_PUSH: if (shadow_depth < CALC_DEPTH) shadow_depth++;
         MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV, MODE_MOD:
            shadow_depth = (shadow_depth > 1) ? shadow_depth - 1 : 1;
         MODE_POP: if (shadow_depth > 0) shadow_depth--;
         default: begin
         end
      endcase
   endtask

   initial begin
      #1_500_000;
      $display("rpn_stack_calculator_core_tb: done, errors");
      $finish;
   end

   initial begin : stimulus
      int item;
      int waited;
      req_bus.valid = 1'b0;
      req_bus.mode = MODE_PUSH;
      req_bus.operand_value = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: empty stack, saturation, zero divisors, wrap, ignored code
      send_op(MODE_POP, '0);
      send_op(MODE_ADD, '0);
      send_op(MODE_POP, '0);
      send_op(MODE_IGNORED, VALUE_MAX);
      send_op(MODE_PUSH, VALUE_MAX);
      send_op(MODE_PUSH, VALUE_MAX);
      send_op(MODE_MUL, '0);
      send_op(MODE_PUSH, VALUE_MIN);
      send_op(MODE_MUL, '0);
      send_op(MODE_PUSH, '0);
      send_op(MODE_DIV, '0);
      send_op(MODE_PUSH, value_type'(1));
      send_op(MODE_MOD, '0);
      send_op(MODE_PUSH, value_type'(1));
      send_op(MODE_DIV, '0);
      send_op(MODE_PUSH, -value_type'(32'h7_8000));
      send_op(MODE_PUSH, value_type'(32'h3_0000));
      send_op(MODE_MOD, '0);
      send_op(MODE_SUB, '0);
      send_op(MODE_PUSH, VALUE_MAX);
      send_op(MODE_ADD, '0);
      send_op(MODE_PUSH, '1);
      send_op(MODE_PUSH, value_type'(32'h1_0000));
      send_op(MODE_MUL, '0);
      while (shadow_depth > 0)
         send_op(MODE_POP, '0);

      // random expressions with fill-to-overflow and drain-to-underflow bursts
      for (item = 0; item < RANDOM_OPS; item++) begin
         if (item % 60 == 0) begin
            req_gaps_on = ($urandom_range(0, 3) != 0);
            rsp_stalls_on = ($urandom_range(0, 3) != 0);
         end
         if (item >= RANDOM_OPS - QUIET_TAIL) begin
            req_gaps_on = 1'b0;
            rsp_stalls_on = 1'b0;
         end
         if (item == 300 || item == 800) begin
            while (shadow_depth < CALC_DEPTH)
               send_op(MODE_PUSH, random_value());
            repeat ($urandom_range(2, 4))
               send_op(MODE_PUSH, random_value());
            fill_count++;
         end
         if (item == 360 || item == 860) begin
            while (shadow_depth > 0)
               send_op(MODE_POP, random_value());
            send_op(MODE_POP, random_value());
            drain_count++;
         end
         send_op(random_mode(shadow_depth), random_value());
      end
      req_bus.valid <= 1'b0;

      // wait for outstanding responses, then let the core settle
      waited = 0;
      @(negedge clock);
      while (pending_count != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      if (pending_count != 0) begin
         $display("rpn_stack_calculator_core_tb: done, errors");
         $finish;
      end else begin
         repeat (SETTLE_CYCLES) @(negedge clock);
         $display("sent %0d push, %0d add/sub/mul/div/mod, %0d pop, %0d ignored; %0d checked",
                  ops_by_mode[MODE_PUSH],
                  ops_by_mode[MODE_ADD] + ops_by_mode[MODE_SUB] + ops_by_mode[MODE_MUL] +
                  ops_by_mode[MODE_DIV] + ops_by_mode[MODE_MOD],
                  ops_by_mode[MODE_POP], ops_by_mode[MODE_IGNORED], compared_count);
         $display("stack filled past full %0d times and drained past empty %0d times",
                  fill_count, drain_count);
         if (mismatch_count == 0 && pending_count == 0)
            $display("rpn_stack_calculator_core_tb: done, clean");
         else
            $display("rpn_stack_calculator_core_tb: done, errors");
         $finish;
      end
   end

endmodule
